// ===== sv/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbe_pkg
// Shared widths, constants and sequencer state type for the B-spline basis
// evaluator.
// ----------------------------------------------------------------------------
package bbe_pkg;

    localparam int MAX_KNOTS   = 64;
    localparam int KADDR_W     = $clog2(MAX_KNOTS);
    localparam int CNT_W       = KADDR_W + 1;
    localparam int KNOT_W      = 32;
    localparam int VAL_W       = 48;
    localparam int FRAC_W      = 24;
    localparam int MAX_DEGREE  = 3;
    localparam int DEG_W       = 2;
    localparam int VADDR_W     = 2;
    localparam int VAL_DEPTH   = MAX_DEGREE + 1;
    localparam int ACT_N       = VAL_DEPTH * VAL_DEPTH;

    // divider: magnitudes of (diff << 24) and of a 33-bit span
    localparam int NUM_W       = 57;
    localparam int DEN_W       = KNOT_W + 1;
    localparam int DIV_CNT_W   = $clog2(NUM_W);
    localparam int DERIV_SHIFT = 40;

    // multiplier: 48-bit magnitude times 64-bit padded quotient, 8 bits a step
    localparam int MUL_DIG_W   = 8;
    localparam int MUL_B_W     = 64;
    localparam int MUL_STEPS   = MUL_B_W / MUL_DIG_W;
    localparam int MUL_CNT_W   = $clog2(MUL_STEPS);
    localparam int ACC_W       = VAL_W + MUL_B_W;

    localparam logic signed [VAL_W-1:0] Q_ONE = VAL_W'(1) << FRAC_W;
    localparam logic signed [VAL_W-1:0] V_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] V_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SUP_RD0,
        ST_SUP_RD1,
        ST_SUP_CHK,
        ST_LEAF,
        ST_NODE_RD0,
        ST_NODE_RD1,
        ST_NODE_RD2,
        ST_NODE_RD3,
        ST_NODE_RD4,
        ST_TERM,
        ST_DIV_WAIT,
        ST_MUL_WAIT,
        ST_NODE_WR,
        ST_RES_RD,
        ST_RES_CAP,
        ST_FINISH
    } bbe_state_t;

endpackage

// ===== sv/bbe_knot_ram.sv =====
// ----------------------------------------------------------------------------
// bbe_knot_ram
// Knot table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbe_knot_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [bbe_pkg::KADDR_W-1:0]  waddr,
    input  logic [bbe_pkg::KNOT_W-1:0]   wdata,
    input  logic [bbe_pkg::KADDR_W-1:0]  raddr,
    output logic [bbe_pkg::KNOT_W-1:0]   rdata
);
    import bbe_pkg::*;

    logic [KNOT_W-1:0] mem [MAX_KNOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bbe_div.sv =====
// ----------------------------------------------------------------------------
// bbe_div
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbe_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bbe_pkg::NUM_W-1:0]  num_mag,
    input  logic [bbe_pkg::DEN_W-1:0]  den_mag,
    output logic                       done,
    output logic [bbe_pkg::NUM_W-1:0]  q_mag
);
    import bbe_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     n_reg;
    logic [DEN_W-1:0]     d_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DEN_W:0]       trial;
    logic [DEN_W:0]       trial_sub;
    logic                 fits;

    assign trial     = {rem_reg, n_reg[NUM_W-1]};
    assign fits      = trial >= {1'b0, d_reg};
    assign trial_sub = trial - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quotient bits shift into the dividend register from the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= num_mag;
            d_reg   <= den_mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done  = done_reg;
    assign q_mag = n_reg;

endmodule

// ===== sv/bbe_mul.sv =====
// ----------------------------------------------------------------------------
// bbe_mul
// Q24.24 product, digit-serial (8 bits a cycle), magnitude truncated and
// clipped to the 48-bit signed range.
// ----------------------------------------------------------------------------
module bbe_mul (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bbe_pkg::VAL_W-1:0]         a_mag,
    input  logic [bbe_pkg::NUM_W-1:0]         b_mag,
    input  logic                              neg,
    output logic                              done,
    output logic signed [bbe_pkg::VAL_W-1:0]  res,
    output logic                              sat
);
    import bbe_pkg::*;

    localparam int SH_W = ACC_W - FRAC_W;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]     a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic                 neg_reg;
    logic [VAL_W+MUL_DIG_W-1:0] part;
    logic [SH_W-1:0]      prod_sh;
    logic [VAL_W-1:0]     lim;
    logic                 over;
    logic [VAL_W-1:0]     mag;

    assign part = a_reg * b_reg[MUL_B_W-1 -: MUL_DIG_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // most significant digit first
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= MUL_B_W'(b_mag);
            neg_reg <= neg;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg << MUL_DIG_W;
            acc_reg <= (acc_reg << MUL_DIG_W) + ACC_W'(part);
        end
    end

    always_comb
    begin
        prod_sh = acc_reg[ACC_W-1:FRAC_W];
        lim     = neg_reg ? VAL_W'(1) << (VAL_W - 1) : VAL_W'(V_MAX);
        over    = (|prod_sh[SH_W-1:VAL_W]) || (prod_sh[VAL_W-1:0] > lim);
        mag     = over ? lim : prod_sh[VAL_W-1:0];
        res     = neg_reg ? -$signed(mag) : $signed(mag);
    end

    assign done = done_reg;
    assign sat  = over;

endmodule

// ===== sv/bspline_basis_evaluator.sv =====
// ----------------------------------------------------------------------------
// bspline_basis_evaluator
// Knot table plus Cox-de Boor evaluator of one basis function or derivative.
// ----------------------------------------------------------------------------
// Knot write: accepted in idle, result offered once the output register is free.
// Evaluate: support checks (up to 10 nodes), then leaves, then each active
//   inner node, whose terms pass through the shared serial divider and
//   digit-serial multiplier. One request at a time; the output register
//   holds a result while the next request is taken.
// Reset: knot_count = 64, no result pending; knot table undefined until written.
// ----------------------------------------------------------------------------
module bspline_basis_evaluator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [bbe_pkg::CNT_W-1:0]          cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic [bbe_pkg::KADDR_W-1:0]        knot_index,
    input  logic signed [bbe_pkg::KNOT_W-1:0]  knot_value,
    input  logic [bbe_pkg::DEG_W-1:0]          spline_degree,
    input  logic [bbe_pkg::KADDR_W-1:0]        basis_index,
    input  logic [bbe_pkg::DEG_W-1:0]          deriv_order,
    input  logic signed [bbe_pkg::KNOT_W-1:0]  x_point,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [bbe_pkg::VAL_W-1:0]   basis_value,
    output logic                               outside_support,
    output logic                               saturated
);
    import bbe_pkg::*;

    bbe_state_t state_reg, state_next;

    logic [CNT_W-1:0]          kc_reg;
    logic [DEG_W-1:0]          k_reg, k_next, d_reg, d_next;
    logic [DEG_W-1:0]          m_reg, m_next, j_reg, j_next;
    logic [KADDR_W-1:0]        i_reg, i_next;
    logic signed [KNOT_W-1:0]  x_reg, x_next, ta_reg, ta_next;
    logic signed [KNOT_W-1:0]  ti_reg, ti_next, tik_reg, tik_next;
    logic signed [KNOT_W-1:0]  ti1_reg, ti1_next, tik1_reg, tik1_next;
    logic signed [VAL_W-1:0]   vlo_reg, vlo_next, vhi_reg, vhi_next;
    logic signed [VAL_W-1:0]   p1_reg, p1_next, p2_reg, p2_next;
    logic signed [VAL_W-1:0]   res_reg, res_next;
    logic [ACT_N-1:0]          act_reg, act_next;
    logic                      term_reg, term_next, qneg_reg, qneg_next;
    logic                      sat_reg, sat_next, outside_reg, outside_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VAL_W-1:0]   out_value_reg, out_value_next;
    logic                      out_outside_reg, out_outside_next;
    logic                      out_sat_reg, out_sat_next;

    // knot memory ports
    logic                      knot_we;
    logic [KADDR_W-1:0]        knot_raddr;
    logic [KNOT_W-1:0]         knot_rdata;
    logic signed [KNOT_W-1:0]  krd;

    // node value scratch memory
    logic signed [VAL_W-1:0]   val_mem [VAL_DEPTH];
    logic                      val_we;
    logic [VADDR_W-1:0]        val_waddr, val_raddr;
    logic signed [VAL_W-1:0]   val_wdata, val_rdata;

    logic                      accept, out_free;
    logic [CNT_W-1:0]          idx_j, idx_jm, idx_j1, idx_jm1, top_end, cnt_lim;
    logic                      cnt_ok, is_top, node_last, reached, in_sup;
    logic                      cur_act, deriv, d_over;
    logic [DEG_W-1:0]          up_m;
    logic signed [KNOT_W-1:0]  t_lo, t_hi;
    logic signed [VAL_W-1:0]   v_sel;
    logic signed [KNOT_W:0]    den_s, diff_s;
    logic [DEN_W-1:0]          den_mag, diff_mag;
    logic [NUM_W-1:0]          num_mag;
    logic [VAL_W-1:0]          a_mag;
    logic                      use_term;
    logic signed [VAL_W:0]     sum_s;
    logic signed [VAL_W-1:0]   sum_clip;
    logic                      sum_ovf;

    logic                      div_start, div_done;
    logic [NUM_W-1:0]          q_mag;
    logic                      mul_start, mul_done, mul_sat;
    logic signed [VAL_W-1:0]   mul_res;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign krd      = $signed(knot_rdata);

    // ---------------- index and support terms ----------------
    always_comb
    begin
        idx_j   = CNT_W'(i_reg) + CNT_W'(j_reg);
        idx_jm  = idx_j + CNT_W'(m_reg);
        idx_j1  = idx_j + CNT_W'(1);
        idx_jm1 = idx_jm + CNT_W'(1);
        top_end = CNT_W'(i_reg) + CNT_W'(k_reg) + CNT_W'(1);
        cnt_lim = (kc_reg > CNT_W'(MAX_KNOTS)) ? CNT_W'(MAX_KNOTS) : kc_reg;
        cnt_ok  = top_end < cnt_lim;
        is_top  = m_reg == k_reg;
        node_last = ({1'b0, j_reg} + {1'b0, m_reg}) == {1'b0, k_reg};
        up_m    = m_reg + 1'b1;
        // a node below the top counts only if a live parent reaches it
        reached = is_top ? 1'b1
                : (((j_reg != '0) && act_reg[{up_m, j_reg - 1'b1}])
                || ((({1'b0, j_reg} + {1'b0, m_reg} + 3'd1) <= {1'b0, k_reg})
                    && act_reg[{up_m, j_reg}]));
        in_sup  = (x_reg > ta_reg) && (x_reg <= krd) && (!is_top || cnt_ok);
        cur_act = act_reg[{m_reg, j_reg}];
        deriv   = ({1'b0, m_reg} + {1'b0, d_reg}) > {1'b0, k_reg};
        d_over  = d_reg > k_reg;
    end

    // ---------------- term operands ----------------
    always_comb
    begin
        t_lo     = term_reg ? ti1_reg : ti_reg;
        t_hi     = term_reg ? tik1_reg : tik_reg;
        v_sel    = term_reg ? vhi_reg : vlo_reg;
        den_s    = {t_hi[KNOT_W-1], t_hi} - {t_lo[KNOT_W-1], t_lo};
        diff_s   = term_reg ? ({tik1_reg[KNOT_W-1], tik1_reg} - {x_reg[KNOT_W-1], x_reg})
                            : ({x_reg[KNOT_W-1], x_reg} - {ti_reg[KNOT_W-1], ti_reg});
        den_mag  = den_s[KNOT_W] ? DEN_W'(-den_s) : DEN_W'(den_s);
        diff_mag = diff_s[KNOT_W] ? DEN_W'(-diff_s) : DEN_W'(diff_s);
        num_mag  = deriv ? (NUM_W'(m_reg) << DERIV_SHIFT)
                         : {1'b0, diff_mag[KNOT_W-1:0], {FRAC_W{1'b0}}};
        use_term = (v_sel != '0) && (t_lo != t_hi);
        a_mag    = v_sel[VAL_W-1] ? VAL_W'(-v_sel) : VAL_W'(v_sel);
        sum_s    = deriv ? ({p1_reg[VAL_W-1], p1_reg} - {p2_reg[VAL_W-1], p2_reg})
                         : ({p1_reg[VAL_W-1], p1_reg} + {p2_reg[VAL_W-1], p2_reg});
        sum_ovf  = sum_s[VAL_W] != sum_s[VAL_W-1];
        sum_clip = sum_ovf ? (sum_s[VAL_W] ? V_MIN : V_MAX) : sum_s[VAL_W-1:0];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_type == REQ_WRITE) ? ST_FINISH : ST_SUP_RD0;
                end
            end
            ST_SUP_RD0:  state_next = ST_SUP_RD1;
            ST_SUP_RD1:  state_next = ST_SUP_CHK;
            ST_SUP_CHK:
            begin
                if (is_top && (!in_sup || d_over))
                begin
                    state_next = ST_FINISH;
                end
                else if (node_last && (m_reg == '0))
                begin
                    state_next = ST_LEAF;
                end
                else
                begin
                    state_next = ST_SUP_RD0;
                end
            end
            ST_LEAF:
            begin
                if (j_reg == k_reg)
                begin
                    state_next = (k_reg == '0) ? ST_RES_RD : ST_NODE_RD0;
                end
            end
            ST_NODE_RD0: state_next = cur_act ? ST_NODE_RD1 : ST_NODE_WR;
            ST_NODE_RD1: state_next = ST_NODE_RD2;
            ST_NODE_RD2: state_next = ST_NODE_RD3;
            ST_NODE_RD3: state_next = ST_NODE_RD4;
            ST_NODE_RD4: state_next = ST_TERM;
            ST_TERM:
            begin
                if (use_term)
                begin
                    state_next = ST_DIV_WAIT;
                end
                else if (term_reg)
                begin
                    state_next = ST_NODE_WR;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL_WAIT;
                end
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = term_reg ? ST_NODE_WR : ST_TERM;
                end
            end
            ST_NODE_WR:
            begin
                state_next = (node_last && is_top) ? ST_RES_RD : ST_NODE_RD0;
            end
            ST_RES_RD:   state_next = ST_RES_CAP;
            ST_RES_CAP:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and memory controls ----------------
    always_comb
    begin
        k_next = k_reg;        d_next = d_reg;      m_next = m_reg;
        j_next = j_reg;        i_next = i_reg;      x_next = x_reg;
        ta_next = ta_reg;      ti_next = ti_reg;    tik_next = tik_reg;
        ti1_next = ti1_reg;    tik1_next = tik1_reg;
        vlo_next = vlo_reg;    vhi_next = vhi_reg;
        p1_next = p1_reg;      p2_next = p2_reg;    res_next = res_reg;
        act_next = act_reg;    term_next = term_reg; qneg_next = qneg_reg;
        sat_next = sat_reg;    outside_next = outside_reg;
        out_value_next   = out_value_reg;
        out_outside_next = out_outside_reg;
        out_sat_next     = out_sat_reg;
        out_valid_next   = out_valid_reg && out_stall;
        knot_we    = 1'b0;
        knot_raddr = idx_j[KADDR_W-1:0];
        val_we     = 1'b0;
        val_waddr  = j_reg;
        val_wdata  = '0;
        val_raddr  = j_reg;
        div_start  = 1'b0;
        mul_start  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_next     = '0;
                    sat_next     = 1'b0;
                    outside_next = 1'b0;
                    if (req_type == REQ_WRITE)
                    begin
                        knot_we = 1'b1;
                    end
                    else
                    begin
                        k_next   = spline_degree;
                        d_next   = deriv_order;
                        i_next   = basis_index;
                        x_next   = x_point;
                        m_next   = spline_degree;
                        j_next   = '0;
                        act_next = '0;
                    end
                end
            end
            ST_SUP_RD0:
            begin
                knot_raddr = idx_j[KADDR_W-1:0];
            end
            ST_SUP_RD1:
            begin
                ta_next    = krd;
                knot_raddr = idx_jm1[KADDR_W-1:0];
            end
            ST_SUP_CHK:
            begin
                act_next[{m_reg, j_reg}] = reached && in_sup;
                if (is_top && !in_sup)
                begin
                    outside_next = 1'b1;
                end
                if (node_last)
                begin
                    j_next = '0;
                    if (m_reg != '0)
                    begin
                        m_next = m_reg - 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_LEAF:
            begin
                val_we    = 1'b1;
                val_wdata = cur_act ? Q_ONE : '0;
                if (j_reg == k_reg)
                begin
                    j_next = '0;
                    m_next = DEG_W'(1);
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_NODE_RD0:
            begin
                knot_raddr = idx_j[KADDR_W-1:0];
                val_raddr  = j_reg;
                p1_next    = '0;
                p2_next    = '0;
                term_next  = 1'b0;
            end
            ST_NODE_RD1:
            begin
                ti_next    = krd;
                vlo_next   = val_rdata;
                knot_raddr = idx_jm[KADDR_W-1:0];
                val_raddr  = j_reg + 1'b1;
            end
            ST_NODE_RD2:
            begin
                tik_next   = krd;
                vhi_next   = val_rdata;
                knot_raddr = idx_j1[KADDR_W-1:0];
            end
            ST_NODE_RD3:
            begin
                ti1_next   = krd;
                knot_raddr = idx_jm1[KADDR_W-1:0];
            end
            ST_NODE_RD4:
            begin
                tik1_next = krd;
            end
            ST_TERM:
            begin
                if (use_term)
                begin
                    div_start = 1'b1;
                    qneg_next = (!deriv && diff_s[KNOT_W]) ^ den_s[KNOT_W];
                end
                else
                begin
                    term_next = 1'b1;
                end
            end
            ST_DIV_WAIT:
            begin
                mul_start = div_done;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    sat_next = sat_reg || mul_sat;
                    if (term_reg)
                    begin
                        p2_next = mul_res;
                    end
                    else
                    begin
                        p1_next   = mul_res;
                        term_next = 1'b1;
                    end
                end
            end
            ST_NODE_WR:
            begin
                val_we    = 1'b1;
                val_wdata = sum_clip;
                sat_next  = sat_reg || sum_ovf;
                if (node_last)
                begin
                    j_next = '0;
                    m_next = m_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_RES_RD:
            begin
                val_raddr = '0;
            end
            ST_RES_CAP:
            begin
                res_next = val_rdata;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_value_next   = res_reg;
                    out_outside_next = outside_reg;
                    out_sat_next     = sat_reg;
                end
            end
            default:
            begin
                knot_raddr = idx_j[KADDR_W-1:0];
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kc_reg        <= CNT_W'(MAX_KNOTS);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                kc_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;       d_reg <= d_next;       m_reg <= m_next;
        j_reg <= j_next;       i_reg <= i_next;       x_reg <= x_next;
        ta_reg <= ta_next;     ti_reg <= ti_next;     tik_reg <= tik_next;
        ti1_reg <= ti1_next;   tik1_reg <= tik1_next;
        vlo_reg <= vlo_next;   vhi_reg <= vhi_next;
        p1_reg <= p1_next;     p2_reg <= p2_next;     res_reg <= res_next;
        act_reg <= act_next;   term_reg <= term_next; qneg_reg <= qneg_next;
        sat_reg <= sat_next;   outside_reg <= outside_next;
        out_value_reg   <= out_value_next;
        out_outside_reg <= out_outside_next;
        out_sat_reg     <= out_sat_next;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata <= val_mem[val_raddr];
    end

    // ---------------- submodules ----------------
    bbe_knot_ram u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (knot_index),
        .wdata (knot_value),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    bbe_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (num_mag),
        .den_mag (den_mag),
        .done    (div_done),
        .q_mag   (q_mag)
    );

    bbe_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a_mag (a_mag),
        .b_mag (q_mag),
        .neg   (v_sel[VAL_W-1] ^ qneg_reg),
        .done  (mul_done),
        .res   (mul_res),
        .sat   (mul_sat)
    );

    assign out_valid       = out_valid_reg;
    assign basis_value     = out_value_reg;
    assign outside_support = out_outside_reg;
    assign saturated       = out_sat_reg;

endmodule
